[src/ppgr_pkg.sv]
// Shared types, constants and helper functions for the pen plotter grid rasterizer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ppgr_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 256;
    localparam int unsigned DEF_MAX_HEIGHT = 256;

    // Wide enough for a row or column index at the largest supported grid.
    localparam int unsigned IDX_BITS = 12;
    localparam int unsigned POS_BITS = 16;
    localparam int unsigned CFG_BITS = 9;

    localparam logic [CFG_BITS-1:0] GRID_SIZE_RESET = 9'd256;

    localparam logic [POS_BITS-1:0] POS_MIN = 16'h8000;
    localparam logic [POS_BITS-1:0] POS_MAX = 16'h7FFF;

    // Command codes.
    localparam logic [2:0] CMD_PEN_UP   = 3'd0;
    localparam logic [2:0] CMD_PEN_DOWN = 3'd1;
    localparam logic [2:0] CMD_LEFT     = 3'd2;
    localparam logic [2:0] CMD_RIGHT    = 3'd3;
    localparam logic [2:0] CMD_UP       = 3'd4;
    localparam logic [2:0] CMD_DOWN     = 3'd5;
    localparam logic [2:0] CMD_READ     = 3'd6;

    // Register indexes on the configuration port.
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // Request from the sequencer to the read-modify-write stage.
    typedef struct packed {
        logic                valid;
        logic                is_read;
        logic [IDX_BITS-1:0] row;
        logic [IDX_BITS-1:0] col;
    } t_req;

    // Status from the read-modify-write stage back to the sequencer.
    typedef struct packed {
        logic clear_busy;
        logic read_bit;
    } t_rmw_status;

    // Grid size register clamped to 1..maxv.
    function automatic logic [POS_BITS-1:0] eff_size(input logic [CFG_BITS-1:0] size,
                                                     input int unsigned maxv);
        logic [POS_BITS-1:0] lim;
        logic [POS_BITS-1:0] res;
        lim = POS_BITS'(maxv);
        if (size == '0) begin
            res = POS_BITS'(1);
        end else if (POS_BITS'(size) > lim) begin
            res = lim;
        end else begin
            res = POS_BITS'(size);
        end
        return res;
    endfunction

    // True when the signed position lies inside the grid of h rows by w columns.
    function automatic logic in_grid(input logic [POS_BITS-1:0] r,
                                     input logic [POS_BITS-1:0] c,
                                     input logic [POS_BITS-1:0] h,
                                     input logic [POS_BITS-1:0] w);
        return !r[POS_BITS-1] && !c[POS_BITS-1] && (r < h) && (c < w);
    endfunction

endpackage

`default_nettype wire

[src/ppgr_bitmap_ram.sv]
// Bitmap storage: one grid row per word, with a registered synchronous read.
// Takes its default sizes from ppgr_pkg.
`default_nettype none

module ppgr_bitmap_ram
    import ppgr_pkg::*;
#(
    parameter int unsigned WIDTH = DEF_MAX_WIDTH,
    parameter int unsigned DEPTH = DEF_MAX_HEIGHT,
    parameter int unsigned AW    = $clog2(DEF_MAX_HEIGHT)
) (
    input  wire              i_clk,
    input  wire              i_rd_en,
    input  wire  [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  wire              i_wr_en,
    input  wire  [AW-1:0]    i_wr_addr,
    input  wire  [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[src/ppgr_rmw.sv]
// Read-modify-write stage around the bitmap memory, with write forwarding
// and the clearing pass after reset. Depends on ppgr_pkg and ppgr_bitmap_ram.
`default_nettype none

module ppgr_rmw
    import ppgr_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_req        i_req,
    output t_rmw_status o_status
);

    localparam int unsigned RW = $clog2(MAX_HEIGHT);
    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam logic [RW-1:0] LAST_ROW = RW'(MAX_HEIGHT - 1);
    localparam logic [MAX_WIDTH-1:0] ONE_BIT = MAX_WIDTH'(1);

    logic                 r_s1_valid;
    logic                 r_s1_read;
    logic [RW-1:0]        r_s1_row;
    logic [CW-1:0]        r_s1_col;
    logic                 r_fwd_valid;
    logic [RW-1:0]        r_fwd_row;
    logic [MAX_WIDTH-1:0] r_fwd_word;
    logic                 r_clr_busy;
    logic [RW-1:0]        r_clr_row;

    logic [MAX_WIDTH-1:0] rd_data;
    logic [MAX_WIDTH-1:0] s1_word;
    logic [MAX_WIDTH-1:0] merged;
    logic                 wr_en;
    logic [RW-1:0]        wr_addr;
    logic [MAX_WIDTH-1:0] wr_data;
    logic                 mark_wr;

    ppgr_bitmap_ram #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (MAX_HEIGHT),
        .AW    (RW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (i_req.valid),
        .i_rd_addr (i_req.row[RW-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // The row written at the previous edge is not yet in the read data.
    always_comb begin
        s1_word = (r_fwd_valid && (r_fwd_row == r_s1_row)) ? r_fwd_word : rd_data;
        merged  = s1_word | (ONE_BIT << r_s1_col);
        mark_wr = r_s1_valid && !r_s1_read;
        wr_en   = r_clr_busy || mark_wr;
        wr_addr = r_clr_busy ? r_clr_row : r_s1_row;
        wr_data = r_clr_busy ? '0 : merged;
    end

    assign o_status.clear_busy = r_clr_busy;
    assign o_status.read_bit   = r_s1_valid && r_s1_read && s1_word[r_s1_col];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr_row   <= '0;
        end else begin
            r_s1_valid  <= i_req.valid;
            r_fwd_valid <= mark_wr;
            if (r_clr_busy) begin
                if (r_clr_row == LAST_ROW) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_row <= r_clr_row + RW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_read  <= i_req.is_read;
        r_s1_row   <= i_req.row[RW-1:0];
        r_s1_col   <= i_req.col[CW-1:0];
        r_fwd_row  <= r_s1_row;
        r_fwd_word <= merged;
    end

endmodule

`default_nettype wire

[src/ppgr_ctrl.sv]
// Command sequencer: arm position, pen state, stepping and the result register.
// Depends on ppgr_pkg; issues bitmap requests to ppgr_rmw.
`default_nettype none

module ppgr_ctrl
    import ppgr_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [2:0]          i_cmd,
    input  wire  [11:0]         i_distance,
    input  wire  [7:0]          i_read_row,
    input  wire  [7:0]          i_read_col,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic                o_cell_value,
    output logic [POS_BITS-1:0] o_arm_row,
    output logic [POS_BITS-1:0] o_arm_col,
    output logic                o_pen_is_down,
    output logic                o_out_of_grid,
    input  wire  [CFG_BITS-1:0] i_grid_width,
    input  wire  [CFG_BITS-1:0] i_grid_height,
    input  t_rmw_status         i_status,
    output t_req                o_req
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MOVE  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [2:0]          r_cmd, n_cmd;
    logic [11:0]         r_cnt, n_cnt;
    logic [POS_BITS-1:0] r_row, n_row;
    logic [POS_BITS-1:0] r_col, n_col;
    logic                r_pen, n_pen;
    logic                r_oob, n_oob;
    logic                r_cell, n_cell;
    logic                r_out_valid, n_out_valid;

    logic [POS_BITS-1:0] eff_w;
    logic [POS_BITS-1:0] eff_h;
    logic [POS_BITS-1:0] step_row;
    logic [POS_BITS-1:0] step_col;
    logic [POS_BITS-1:0] rd_row16;
    logic [POS_BITS-1:0] rd_col16;
    logic                accept;

    assign eff_w    = eff_size(i_grid_width, MAX_WIDTH);
    assign eff_h    = eff_size(i_grid_height, MAX_HEIGHT);
    assign rd_row16 = POS_BITS'(i_read_row);
    assign rd_col16 = POS_BITS'(i_read_col);
    assign o_ready  = (r_state == ST_IDLE) && !i_status.clear_busy;
    assign accept   = i_valid && o_ready;
    assign o_valid  = r_out_valid;

    // One saturating step in the direction of the current move.
    always_comb begin
        step_row = r_row;
        step_col = r_col;
        case (r_cmd)
            CMD_LEFT:  step_col = (r_col == POS_MIN) ? r_col : r_col - POS_BITS'(1);
            CMD_RIGHT: step_col = (r_col == POS_MAX) ? r_col : r_col + POS_BITS'(1);
            CMD_UP:    step_row = (r_row == POS_MIN) ? r_row : r_row - POS_BITS'(1);
            CMD_DOWN:  step_row = (r_row == POS_MAX) ? r_row : r_row + POS_BITS'(1);
            default:   step_row = r_row;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_cnt       = r_cnt;
        n_row       = r_row;
        n_col       = r_col;
        n_pen       = r_pen;
        n_oob       = r_oob;
        n_cell      = r_cell;
        n_out_valid = r_out_valid && !i_ready;
        o_req       = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd  = i_cmd;
                    n_cnt  = i_distance;
                    n_oob  = 1'b0;
                    n_cell = 1'b0;
                    case (i_cmd)
                        CMD_PEN_UP: begin
                            n_pen   = 1'b0;
                            n_state = ST_DONE;
                        end
                        CMD_PEN_DOWN: begin
                            n_pen = 1'b1;
                            if (in_grid(r_row, r_col, eff_h, eff_w)) begin
                                o_req.valid = 1'b1;
                                o_req.row   = r_row[IDX_BITS-1:0];
                                o_req.col   = r_col[IDX_BITS-1:0];
                            end else begin
                                n_oob = 1'b1;
                            end
                            n_state = ST_DRAIN;
                        end
                        CMD_LEFT, CMD_RIGHT, CMD_UP, CMD_DOWN: begin
                            n_state = (i_distance == '0) ? ST_DONE : ST_MOVE;
                        end
                        CMD_READ: begin
                            if (in_grid(rd_row16, rd_col16, eff_h, eff_w)) begin
                                o_req.valid   = 1'b1;
                                o_req.is_read = 1'b1;
                                o_req.row     = rd_row16[IDX_BITS-1:0];
                                o_req.col     = rd_col16[IDX_BITS-1:0];
                            end
                            n_state = ST_DRAIN;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_MOVE: begin
                n_row = step_row;
                n_col = step_col;
                if (r_pen) begin
                    if (in_grid(step_row, step_col, eff_h, eff_w)) begin
                        o_req.valid = 1'b1;
                        o_req.row   = step_row[IDX_BITS-1:0];
                        o_req.col   = step_col[IDX_BITS-1:0];
                    end else begin
                        n_oob = 1'b1;
                    end
                end
                n_cnt = r_cnt - 12'd1;
                if (r_cnt == 12'd1) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last mark or the read finishes in this cycle.
                n_cell  = i_status.read_bit;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_pen       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_pen       <= n_pen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_cnt  <= n_cnt;
        r_oob  <= n_oob;
        r_cell <= n_cell;
        if ((r_state == ST_DONE) && (!r_out_valid || i_ready)) begin
            o_cell_value  <= r_cell;
            o_arm_row     <= r_row;
            o_arm_col     <= r_col;
            o_pen_is_down <= r_pen;
            o_out_of_grid <= r_oob;
        end
    end

endmodule

`default_nettype wire

[src/pen_plotter_grid_rasterizer_top.sv]
// Top level of the pen plotter grid rasterizer: configuration registers,
// sequencer and bitmap read-modify-write stage. Depends on ppgr_pkg, ppgr_ctrl, ppgr_rmw.
`default_nettype none

// The block drives a pen arm over a one-bit bitmap of MAX_HEIGHT rows by MAX_WIDTH
// columns, held in a simple dual-port memory with one grid row per word. After reset
// the bitmap is cleared by a pass that writes one row per cycle, so the block accepts
// no item until the pass is done (configuration writes are taken at any time). Each
// command item produces exactly one result item. A move of distance d steps the arm
// one cell per cycle, then passes drain and done; pen down and read cell pass drain
// and done, while pen up, an unused code or a zero-length move go straight to done.
// The step loop is bounded by the memory, which sees one read and one write of a row
// per cycle; a row written in one cycle and read in the next is forwarded from the
// write path. A result waits in an output register, so the next item can be accepted
// before the previous result is taken. Marks outside the configured grid are dropped
// and flagged in out_of_grid; arm coordinates saturate at the signed 16-bit range.
// Registers: grid_width at byte address 0, grid_height at byte address 4, 9 bits each.
module pen_plotter_grid_rasterizer_top
    import ppgr_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // Command items.
    input  wire                i_valid,
    output logic               o_ready,
    input  wire  [2:0]         i_cmd,
    input  wire  [11:0]        i_distance,
    input  wire  [7:0]         i_read_row,
    input  wire  [7:0]         i_read_col,
    // Result items.
    output logic               o_valid,
    input  wire                i_ready,
    output logic               o_cell_value,
    output logic signed [15:0] o_arm_row,
    output logic signed [15:0] o_arm_col,
    output logic               o_pen_is_down,
    output logic               o_out_of_grid,
    // Configuration port.
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [2:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [CFG_BITS-1:0] r_grid_width;
    logic [CFG_BITS-1:0] r_grid_height;
    logic                cfg_wr;
    t_req                req;
    t_rmw_status         status;
    logic [POS_BITS-1:0] arm_row;
    logic [POS_BITS-1:0] arm_col;

    // The port never stalls; a write lands on the access cycle.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_SIZE_RESET;
            r_grid_height <= GRID_SIZE_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_GRID_WIDTH) begin
                r_grid_width <= pwdata[CFG_BITS-1:0];
            end else begin
                r_grid_height <= pwdata[CFG_BITS-1:0];
            end
        end
    end

    // Register read-back, zero-extended to the data bus.
    assign prdata = (paddr[2] == REG_GRID_HEIGHT) ? 32'(r_grid_height) : 32'(r_grid_width);

    // The sequencer tracks the arm and pen and issues at most one bitmap access per cycle.
    ppgr_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_distance    (i_distance),
        .i_read_row    (i_read_row),
        .i_read_col    (i_read_col),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_cell_value  (o_cell_value),
        .o_arm_row     (arm_row),
        .o_arm_col     (arm_col),
        .o_pen_is_down (o_pen_is_down),
        .o_out_of_grid (o_out_of_grid),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .i_status      (status),
        .o_req         (req)
    );

    assign o_arm_row = arm_row;
    assign o_arm_col = arm_col;

    // The read-modify-write stage owns the bitmap memory and its clearing pass.
    ppgr_rmw #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_rmw (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .o_status (status)
    );

`ifndef SYNTHESIS
    // No command may start while the bitmap is still being cleared.
    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.clear_busy |-> !o_ready)
        else $error("item accepted during the bitmap clearing pass");

    // Every accepted item takes the sequencer out of idle, so ready drops.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("sequencer ready again right after accepting an item");

    // Only a read reports a cell and only marking commands flag out-of-grid marks.
    a_cell_or_oob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_cell_value && o_out_of_grid))
        else $error("result reports both a read cell and an out-of-grid mark");

    // Bitmap requests are only issued from an accepted item or an ongoing move.
    a_req_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req.valid && o_ready) |-> i_valid)
        else $error("bitmap access issued without an item");
`endif

endmodule

`default_nettype wire

[dv/ppgr_plot_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the pen plotter grid rasterizer testbench: result type and a class
// that predicts each command's result and checks the block's output. Depends on ppgr_pkg.

package ppgr_plot_scoreboard_pkg;
    import ppgr_pkg::*;

    // The package has no name for the spare command code.
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef struct {
        logic               cell_bit;
        logic signed [15:0] row;
        logic signed [15:0] col;
        logic               pen;
        logic               off_grid;
    } t_plot_result;

    class plot_scoreboard;
        bit [DEF_MAX_WIDTH-1:0] ink [DEF_MAX_HEIGHT];
        int                     arm_r;
        int                     arm_c;
        bit                     pen_low;
        logic [CFG_BITS-1:0]    width_reg;
        logic [CFG_BITS-1:0]    height_reg;
        t_plot_result           awaited [$];
        int unsigned            mismatches;
        int unsigned            results_seen;

        function new();
            foreach (ink[i]) ink[i] = '0;
            arm_r        = 0;
            arm_c        = 0;
            pen_low      = 1'b0;
            width_reg    = GRID_SIZE_RESET;
            height_reg   = GRID_SIZE_RESET;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function int clamp_size(logic [CFG_BITS-1:0] setting, int maxv);
            if (setting == '0) return 1;
            if (int'(setting) > maxv) return maxv;
            return int'(setting);
        endfunction

        function int grid_cols();
            return clamp_size(width_reg, DEF_MAX_WIDTH);
        endfunction

        function int grid_rows();
            return clamp_size(height_reg, DEF_MAX_HEIGHT);
        endfunction

        function bit on_grid(int r, int c);
            return r >= 0 && c >= 0 && r < grid_rows() && c < grid_cols();
        endfunction

        // Marks the cell under the arm; returns 1 when it lies off the grid.
        function bit mark_arm();
            if (!on_grid(arm_r, arm_c)) return 1'b1;
            ink[arm_r][arm_c] = 1'b1;
            return 1'b0;
        endfunction

        function int step_coord(int p, int dir);
            if (dir < 0) return (p > -32768) ? p - 1 : p;
            return (p < 32767) ? p + 1 : p;
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == REG_GRID_WIDTH) begin
                width_reg = value[CFG_BITS-1:0];
            end else begin
                height_reg = value[CFG_BITS-1:0];
            end
        endfunction

        function void note_command(logic [2:0] cmd, logic [11:0] steps,
                                   logic [7:0] rr, logic [7:0] rc);
            t_plot_result res;
            bit           outside;
            res.cell_bit = 1'b0;
            outside      = 1'b0;
            case (cmd)
                CMD_PEN_UP: begin
                    pen_low = 1'b0;
                end
                CMD_PEN_DOWN: begin
                    pen_low = 1'b1;
                    outside = mark_arm();
                end
                CMD_LEFT, CMD_RIGHT, CMD_UP, CMD_DOWN: begin
                    for (int unsigned n = 0; n < steps; n++) begin
                        if (cmd == CMD_LEFT) arm_c = step_coord(arm_c, -1);
                        else if (cmd == CMD_RIGHT) arm_c = step_coord(arm_c, 1);
                        else if (cmd == CMD_UP) arm_r = step_coord(arm_r, -1);
                        else arm_r = step_coord(arm_r, 1);
                        if (pen_low && mark_arm()) outside = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (on_grid(int'(rr), int'(rc))) res.cell_bit = ink[rr][rc];
                end
                default: begin
                end
            endcase
            res.row      = 16'(arm_r);
            res.col      = 16'(arm_c);
            res.pen      = pen_low;
            res.off_grid = outside;
            awaited.push_back(res);
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_plot_result got);
            t_plot_result want;
            results_seen++;
            if (awaited.size() == 0) begin
                mismatches++;
                $display("%0t: result item with none expected, actual row %0d col %0d",
                         $time, got.row, got.col);
                return;
            end
            want = awaited.pop_front();
            compare_field("cell_value", want.cell_bit, got.cell_bit);
            compare_field("arm_row", want.row, got.row);
            compare_field("arm_col", want.col, got.col);
            compare_field("pen_is_down", want.pen, got.pen);
            compare_field("out_of_grid", want.off_grid, got.off_grid);
        endfunction

        function int pending_count();
            return awaited.size();
        endfunction
    endclass

endpackage

[dv/pen_plotter_grid_rasterizer_top_test.sv]
`timescale 1ns / 1ps
// Top-level testbench of the pen plotter grid rasterizer: drives command items and
// grid size writes, and checks each result item. Depends on ppgr_pkg,
// ppgr_plot_scoreboard_pkg and the block's RTL.

module pen_plotter_grid_rasterizer_top_test;
    import ppgr_pkg::*;
    import ppgr_plot_scoreboard_pkg::*;

    // The receiver's long hold-off, long enough for the block to fill and stall.
    localparam int HOLD_OFF_CYCLES = 300;
    // Cycles left after the last result before a register write or the end.
    localparam int DRAIN_CYCLES    = 8;
    localparam int PHASE_ITEMS     = 42;
    localparam int NUM_PHASES      = 7;
    // Beyond this distance from the origin the arm is brought home.
    localparam int FAR_LIMIT       = 1024;
    localparam int MAX_STEP        = 4095;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_valid    = 1'b0;
    logic               o_ready;
    logic [2:0]         i_cmd      = CMD_PEN_UP;
    logic [11:0]        i_distance = '0;
    logic [7:0]         i_read_row = '0;
    logic [7:0]         i_read_col = '0;
    logic               o_valid;
    logic               i_ready    = 1'b1;
    logic               o_cell_value;
    logic signed [15:0] o_arm_row;
    logic signed [15:0] o_arm_col;
    logic               o_pen_is_down;
    logic               o_out_of_grid;
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [2:0]         paddr      = '0;
    logic [31:0]        pwdata     = '0;
    logic [31:0]        prdata;
    logic               pready;

    pen_plotter_grid_rasterizer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_distance    (i_distance),
        .i_read_row    (i_read_row),
        .i_read_col    (i_read_col),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_cell_value  (o_cell_value),
        .o_arm_row     (o_arm_row),
        .o_arm_col     (o_arm_col),
        .o_pen_is_down (o_pen_is_down),
        .o_out_of_grid (o_out_of_grid),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // The predictor and the queue of results still owed by the block.
    plot_scoreboard arm_tracker = new();

    // Set by the stimulus to make the result side hold off for a long stretch.
    bit hold_off_request = 1'b0;
    // Items left in a run with no idling, one counter for each side.
    int send_burst = 0;
    int sink_burst = 0;

    int unsigned items_sent  = 0;
    int unsigned moves_sent  = 0;
    int unsigned reads_sent  = 0;
    int unsigned grid_setups = 0;

    // Each side draws its idle cycles per item. Now and then it starts a run of
    // items with no idling at all, so back-to-back traffic is covered too.
    function automatic int next_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [11:0] any_dist();
        return 12'($urandom);
    endfunction

    function automatic logic [7:0] any_index();
        return 8'($urandom);
    endfunction

    // Offers one command item and holds it until the block takes it. The item is
    // handed to the predictor at the edge where it is accepted. Valid is only
    // lowered when an idle gap follows, so back-to-back items keep it high.
    task automatic issue_command(input logic [2:0] cmd, input logic [11:0] move_len,
                                 input logic [7:0] rr, input logic [7:0] rc);
        int gap;
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_distance <= move_len;
        i_read_row <= rr;
        i_read_col <= rc;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        arm_tracker.note_command(cmd, move_len, rr, rc);
        items_sent++;
        if (cmd inside {CMD_LEFT, CMD_RIGHT, CMD_UP, CMD_DOWN}) moves_sent++;
        if (cmd == CMD_READ) reads_sent++;
        gap = next_wait(send_burst);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops offering items and waits until every result has come back. Every
    // command yields a result, so the block is idle once the queue is empty;
    // the trailing drain cycles cover the output register settling.
    task automatic wait_until_drained();
        i_valid <= 1'b0;
        while (arm_tracker.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: a setup phase, then an access phase that completes on pready.
    // The upper data bits are random since only the low nine bits are kept.
    // The bus then goes idle so that a second write starts with a fresh setup phase.
    task automatic write_register(input logic idx, input logic [CFG_BITS-1:0] value);
        logic [31:0] word;
        word = {23'($urandom), value};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        arm_tracker.set_register(idx, word);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_grid(input logic [CFG_BITS-1:0] cols, input logic [CFG_BITS-1:0] rows);
        wait_until_drained();
        write_register(REG_GRID_WIDTH, cols);
        write_register(REG_GRID_HEIGHT, rows);
        grid_setups++;
    endtask

    // Moves the arm back to the origin, rows first, in steps of at most the
    // largest distance. The pen stays as it is, so the way back may mark cells.
    task automatic home_arm();
        int          move_len;
        logic [2:0]  cmd;
        while (arm_tracker.arm_r != 0 || arm_tracker.arm_c != 0) begin
            if (arm_tracker.arm_r != 0) begin
                move_len = (arm_tracker.arm_r > 0) ? arm_tracker.arm_r : -arm_tracker.arm_r;
                cmd      = (arm_tracker.arm_r > 0) ? CMD_UP : CMD_DOWN;
            end else begin
                move_len = (arm_tracker.arm_c > 0) ? arm_tracker.arm_c : -arm_tracker.arm_c;
                cmd      = (arm_tracker.arm_c > 0) ? CMD_LEFT : CMD_RIGHT;
            end
            if (move_len > MAX_STEP) move_len = MAX_STEP;
            issue_command(cmd, 12'(move_len), any_index(), any_index());
        end
    endtask

    // Short hand-written sequence: the full grid first, then a one-column grid
    // from an out-of-range width, then the full grid again to show that marks
    // survive a change of grid size.
    task automatic run_directed();
        // Reading a fresh cell, then marking the origin twice.
        issue_command(CMD_READ, any_dist(), 8'd0, 8'd0);
        issue_command(CMD_PEN_DOWN, any_dist(), any_index(), any_index());
        issue_command(CMD_PEN_DOWN, any_dist(), any_index(), any_index());
        issue_command(CMD_READ, any_dist(), 8'd0, 8'd0);
        // A zero-length move, then a short drawn path.
        issue_command(CMD_RIGHT, 12'd0, any_index(), any_index());
        issue_command(CMD_RIGHT, 12'd5, any_index(), any_index());
        issue_command(CMD_DOWN, 12'd3, any_index(), any_index());
        issue_command(CMD_READ, any_dist(), 8'd3, 8'd5);
        issue_command(CMD_READ, any_dist(), 8'd255, 8'd255);
        // Drawing above the top edge: those marks are dropped and flagged.
        issue_command(CMD_UP, 12'd10, any_index(), any_index());
        issue_command(CMD_PEN_UP, any_dist(), any_index(), any_index());
        issue_command(CMD_DOWN, 12'd7, any_index(), any_index());
        issue_command(CMD_UNUSED, any_dist(), any_index(), any_index());
        issue_command(CMD_LEFT, 12'd1, any_index(), any_index());
        // Width zero clamps to one column, height 511 clamps to the full height.
        set_grid(9'd0, 9'd511);
        issue_command(CMD_READ, any_dist(), 8'd3, 8'd5);
        issue_command(CMD_READ, any_dist(), 8'd0, 8'd0);
        issue_command(CMD_PEN_DOWN, any_dist(), any_index(), any_index());
        issue_command(CMD_LEFT, 12'd4, any_index(), any_index());
        // Back to the full grid: the earlier marks are still there.
        set_grid(9'd256, 9'd256);
        issue_command(CMD_READ, any_dist(), 8'd3, 8'd5);
        issue_command(CMD_READ, any_dist(), 8'd0, 8'd4);
        issue_command(CMD_PEN_UP, any_dist(), any_index(), any_index());
    endtask

    // Drives the arm far enough in each direction to pin it at the 16-bit limit,
    // with further steps that must leave it in place, then brings it home.
    task automatic run_far_trips();
        logic [2:0] heading [4];
        heading = '{CMD_LEFT, CMD_RIGHT, CMD_UP, CMD_DOWN};
        foreach (heading[k]) begin
            issue_command(($urandom_range(0, 1) != 0) ? CMD_PEN_DOWN : CMD_PEN_UP,
                          any_dist(), any_index(), any_index());
            repeat (9) issue_command(heading[k], 12'(MAX_STEP), any_index(), any_index());
            home_arm();
        end
    endtask

    // One random command. Moves lean back toward the grid when the arm has left
    // it, and distances are mostly on the scale of the grid, so that drawing and
    // reading keep meeting each other. Fields that a command ignores stay random.
    task automatic random_command();
        int          pick;
        int          roll;
        int          span;
        int          top;
        logic [2:0]  cmd;
        logic [11:0] move_len;
        logic [7:0]  rr;
        logic [7:0]  rc;
        move_len = any_dist();
        rr       = any_index();
        rc       = any_index();
        pick     = $urandom_range(0, 99);
        if (pick < 8) begin
            cmd = CMD_PEN_UP;
        end else if (pick < 20) begin
            cmd = CMD_PEN_DOWN;
        end else if (pick < 45) begin
            cmd = CMD_READ;
            if ($urandom_range(0, 9) < 7) begin
                // Mostly inside the grid or one past its edge.
                top = (arm_tracker.grid_rows() > 255) ? 255 : arm_tracker.grid_rows();
                rr  = 8'($urandom_range(0, top));
                top = (arm_tracker.grid_cols() > 255) ? 255 : arm_tracker.grid_cols();
                rc  = 8'($urandom_range(0, top));
            end
        end else if (pick < 50) begin
            cmd = CMD_UNUSED;
        end else begin
            roll = $urandom_range(0, 3);
            if ($urandom_range(0, 1) != 0) begin
                span = arm_tracker.grid_cols();
                if (arm_tracker.arm_c < 0) cmd = (roll != 0) ? CMD_RIGHT : CMD_LEFT;
                else if (arm_tracker.arm_c >= span) cmd = (roll != 0) ? CMD_LEFT : CMD_RIGHT;
                else cmd = roll[0] ? CMD_RIGHT : CMD_LEFT;
            end else begin
                span = arm_tracker.grid_rows();
                if (arm_tracker.arm_r < 0) cmd = (roll != 0) ? CMD_DOWN : CMD_UP;
                else if (arm_tracker.arm_r >= span) cmd = (roll != 0) ? CMD_UP : CMD_DOWN;
                else cmd = roll[0] ? CMD_DOWN : CMD_UP;
            end
            roll = $urandom_range(0, 99);
            if (roll < 60) move_len = 12'($urandom_range(0, 15));
            else if (roll < 90) move_len = 12'($urandom_range(0, span + 16));
            else if (roll < 98) move_len = 12'($urandom_range(0, 300));
            // Otherwise the full-width random distance stands.
        end
        issue_command(cmd, move_len, rr, rc);
        if (arm_tracker.arm_r > FAR_LIMIT || arm_tracker.arm_r < -FAR_LIMIT ||
            arm_tracker.arm_c > FAR_LIMIT || arm_tracker.arm_c < -FAR_LIMIT) begin
            home_arm();
        end
    endtask

    // Random traffic under a series of grid sizes: full, small, the smallest,
    // zero (clamped to one), oversized (clamped to the maximum), random, and a
    // wide flat grid. One phase makes the result side hold off while items keep
    // coming; another has the command side pause until every result is back.
    task automatic run_random_phases();
        int unsigned cols_set [NUM_PHASES];
        int unsigned rows_set [NUM_PHASES];
        cols_set = '{256, 16, 1, 0, 511, 1, 255};
        rows_set = '{256, 8, 1, 0, 300, 1, 2};
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 5) begin
                cols_set[p] = $urandom_range(1, 256);
                rows_set[p] = $urandom_range(1, 256);
            end
            set_grid(9'(cols_set[p]), 9'(rows_set[p]));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == 20) begin
                    hold_off_request = 1'b1;
                    send_burst       = 14;
                end
                if (p == 3 && n == 30) wait_until_drained();
                random_command();
            end
        end
    endtask

    // Result side: draws a stall before each result item, takes it at the edge
    // where valid and ready are both high, and hands it to the scoreboard.
    initial begin : result_sink
        int           stall;
        t_plot_result got;
        forever begin
            stall = next_wait(sink_burst);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                stall            = HOLD_OFF_CYCLES;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                i_ready <= 1'b1;
            end
            do @(posedge i_clk); while (o_valid !== 1'b1);
            got.cell_bit = o_cell_value;
            got.row      = o_arm_row;
            got.col      = o_arm_col;
            got.pen      = o_pen_is_down;
            got.off_grid = o_out_of_grid;
            arm_tracker.check_result(got);
        end
    end

    // Main sequence. After reset the block clears its bitmap and holds off items
    // for a while; the first command simply waits for ready.
    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_far_trips();
        run_random_phases();
        wait_until_drained();
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d command items (%0d moves, %0d reads) under %0d grid settings,",
                 items_sent, moves_sent, reads_sent, grid_setups);
        $display("including saturating trips in all four directions; %0d results checked.",
                 arm_tracker.results_seen);
        if (arm_tracker.mismatches == 0 && arm_tracker.pending_count() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Far beyond the slowest correct run.
    initial begin : watchdog
        #30_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, arm_tracker.pending_count());
        $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
src/ppgr_pkg.sv
src/ppgr_bitmap_ram.sv
src/ppgr_rmw.sv
src/ppgr_ctrl.sv
src/pen_plotter_grid_rasterizer_top.sv
dv/ppgr_plot_scoreboard_pkg.sv
dv/pen_plotter_grid_rasterizer_top_test.sv
